// ----- design/dspm_pkg.sv -----
// ============================================================================
// dspm_pkg
// Shared types and constants of the dot-star pattern matcher.
// ============================================================================
package dspm_pkg;

    // Size of the atom store
    localparam int MAX_ATOMS = 16;
    localparam int ATOM_IW   = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ATOMS + 1);
    localparam int POS_W     = MAX_ATOMS + 1;

    // Special pattern bytes
    localparam logic [7:0] SYM_STAR = 8'd42;
    localparam logic [7:0] SYM_ANY  = 8'd46;

    // Input word action codes
    typedef enum logic [1:0] {
        ACT_BEGIN   = 2'd0,
        ACT_PATTERN = 2'd1,
        ACT_TEXT    = 2'd2,
        ACT_END     = 2'd3
    } t_action;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_ORDER    = 2'd2
    } t_status;

    // Output register state
    typedef enum logic {
        ST_EMPTY = 1'b0,
        ST_FULL  = 1'b1
    } t_out_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic do_begin;
        logic do_pattern;
        logic do_text;
        logic do_end;
    } t_dp_cmd;

endpackage

// ----- design/dspm_in_if.sv -----
// ============================================================================
// dspm_in_if
// Input channel: one word carries an action code and a symbol byte.
// ============================================================================
interface dspm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] symbol;

    modport source (output valid, output action, output symbol, input ready);
    modport sink   (input valid, input action, input symbol, output ready);
endinterface

// ----- design/dspm_out_if.sv -----
// ============================================================================
// dspm_out_if
// Result channel: match flag and status of one end of text.
// ============================================================================
interface dspm_out_if;
    logic       valid;
    logic       ready;
    logic       matched;
    logic [1:0] status;

    modport source (output valid, output matched, output status, input ready);
    modport sink   (input valid, input matched, input status, output ready);
endinterface

// ----- design/dspm_ctrl.sv -----
// ============================================================================
// dspm_ctrl
// Controller: decodes the input word into datapath commands and tracks the
// one-deep result register.
// ============================================================================
module dspm_ctrl
    import dspm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_action,
    input  logic       i_out_ready,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    t_out_state r_state;
    t_out_state n_state;
    logic       accept;
    t_action    action;

    assign action = t_action'(i_in_action);

    // Take a new word when the result register is free or being drained
    assign o_in_ready = (r_state == ST_EMPTY) || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_EMPTY: begin
                if (accept && action == ACT_END) n_state = ST_FULL;
            end
            ST_FULL: begin
                if (accept && action == ACT_END) n_state = ST_FULL;
                else if (i_out_ready)           n_state = ST_EMPTY;
            end
            default: n_state = ST_EMPTY;
        endcase
    end

    // Outputs: result valid and datapath commands
    always_comb begin
        o_out_valid = (r_state == ST_FULL);
        o_cmd       = '0;
        if (accept) begin
            unique case (action)
                ACT_BEGIN:   o_cmd.do_begin   = 1'b1;
                ACT_PATTERN: o_cmd.do_pattern = 1'b1;
                ACT_TEXT:    o_cmd.do_text    = 1'b1;
                ACT_END:     o_cmd.do_end     = 1'b1;
                default:     o_cmd            = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/dspm_datapath.sv -----
// ============================================================================
// dspm_datapath
// Datapath: atom store, live position set with star closure, error flags
// and the result register.
// ============================================================================
module dspm_datapath
    import dspm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [7:0] i_symbol,
    output logic       o_matched,
    output logic [1:0] o_status
);

    // Atom store, one cell per atom
    logic [7:0]           r_atom_byte [MAX_ATOMS];
    logic [MAX_ATOMS-1:0] r_atom_any;
    logic [MAX_ATOMS-1:0] r_atom_star;

    logic [CNT_W-1:0] r_count;
    logic [POS_W-1:0] r_live;
    logic             r_text_started;
    logic             r_overflow;
    logic             r_order_err;
    logic             r_matched;
    t_status          r_status;

    logic [MAX_ATOMS-1:0] atom_valid;
    logic [POS_W-1:0]     star_mask;
    logic [POS_W-1:0]     cur;
    logic [POS_W-1:0]     gen;
    logic [POS_W-1:0]     sum;
    logic [POS_W-1:0]     step_next;
    logic [CNT_W-1:0]     last_idx;
    logic                 fold_star;
    t_status              status_now;

    // Mark cells that hold a stored atom
    always_comb begin
        for (int i = 0; i < MAX_ATOMS; i++) begin
            atom_valid[i] = (CNT_W'(i) < r_count);
        end
    end

    // Close the live set over starred atoms: a carry chain where a starred
    // cell propagates liveness and a live starred cell generates it
    assign star_mask = {1'b0, r_atom_star & atom_valid};
    assign gen       = r_live & star_mask;
    assign sum       = star_mask + gen;
    assign cur       = r_live | (sum ^ star_mask ^ gen);

    // Advance every live cell whose atom accepts the text byte
    always_comb begin
        step_next = '0;
        for (int i = 0; i < MAX_ATOMS; i++) begin
            if (cur[i] && atom_valid[i] &&
                (r_atom_any[i] || r_atom_byte[i] == i_symbol)) begin
                if (r_atom_star[i]) step_next[i]     = 1'b1;
                else                step_next[i + 1] = 1'b1;
            end
        end
    end

    // Fold a star into the last atom when it is not starred yet
    assign last_idx  = r_count - CNT_W'(1);
    assign fold_star = (i_symbol == SYM_STAR) && (r_count != '0) &&
                       !r_atom_star[last_idx[ATOM_IW-1:0]];

    assign status_now = r_overflow  ? STAT_OVERFLOW :
                        r_order_err ? STAT_ORDER    : STAT_OK;

    // Control state: count, live set and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.do_begin) begin
            r_count        <= '0;
            r_live         <= POS_W'(1);
            r_text_started <= 1'b0;
            r_overflow     <= 1'b0;
            r_order_err    <= 1'b0;
        end else if (i_cmd.do_pattern) begin
            if (r_text_started) begin
                r_order_err <= 1'b1;
            end else if (!r_overflow && !fold_star) begin
                if (r_count == CNT_W'(MAX_ATOMS)) r_overflow <= 1'b1;
                else                              r_count    <= r_count + CNT_W'(1);
            end
        end else if (i_cmd.do_text) begin
            r_text_started <= 1'b1;
            r_live         <= step_next;
        end
    end

    // Atom store writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_pattern && !r_text_started && !r_overflow) begin
            if (fold_star) begin
                r_atom_star[last_idx[ATOM_IW-1:0]] <= 1'b1;
            end else if (r_count != CNT_W'(MAX_ATOMS)) begin
                r_atom_byte[r_count[ATOM_IW-1:0]] <= i_symbol;
                r_atom_any[r_count[ATOM_IW-1:0]]  <= (i_symbol == SYM_ANY);
                r_atom_star[r_count[ATOM_IW-1:0]] <= 1'b0;
            end
        end
    end

    // Capture the result on end of text
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_end) begin
            r_status  <= status_now;
            r_matched <= (status_now == STAT_OK) && cur[r_count];
        end
    end

    assign o_matched = r_matched;
    assign o_status  = r_status;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ATOMS))
        else $error("atom count beyond store size");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (r_count == CNT_W'(MAX_ATOMS)))
        else $error("overflow flagged with free store");

    a_begin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_begin |=> (r_count == '0 && r_live == POS_W'(1) && !r_text_started))
        else $error("begin did not clear match state");

    a_live_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_live >> r_count) <= POS_W'(1))
        else $error("live position past last atom");

endmodule

// ----- design/dot_star_pattern_matcher.sv -----
// ============================================================================
// dot_star_pattern_matcher
// Whole-string matcher for patterns of literal bytes, '.' and '*'.
// ============================================================================
// Send a begin word, the raw pattern bytes, the text bytes and an end word;
// the end word yields one result word (match flag and status), all others
// yield none. Text streams at one byte per cycle while no result waits
// untaken: each atom cell updates its live bit in parallel and the star
// closure is a single carry chain across the cells. The result appears
// in the cycle after its end word is taken and sits in a one-deep output
// register; while it waits untaken every input word stalls, and input flows
// again in the cycle that the result is taken. Up to MAX_ATOMS atoms are
// stored; a star after an unstarred atom folds into it.
module dot_star_pattern_matcher
    import dspm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dspm_in_if.sink     i_in,
    dspm_out_if.source  o_out
);

    t_dp_cmd    cmd;
    logic       in_ready;
    logic       out_valid;
    logic       matched;
    logic [1:0] status;

    // Sequence words and manage the result register
    dspm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // Hold the pattern and track live positions
    dspm_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_symbol  (i_in.symbol),
        .o_matched (matched),
        .o_status  (status)
    );

    assign i_in.ready    = in_ready;
    assign o_out.valid   = out_valid;
    assign o_out.matched = matched;
    assign o_out.status  = status;

endmodule

// ----- sim/dot_star_pattern_matcher_tb.sv -----
// ============================================================================
// dot_star_pattern_matcher_tb
// Self-checking bench for the dot-star pattern matcher. A word queue is
// filled with directed cases (star folding, literal stars, wildcard, repeated
// end, pattern after text, empty pattern and text, operation without a begin),
// then with random match sequences, overflowing patterns, order errors and
// noise. A driver streams the words with random gaps, the result side stalls
// at random, and a bit-set predictor checks every result word.
// ============================================================================
module dot_star_pattern_matcher_tb
    import dspm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RAND_WORDS = 1450;
    localparam int unsigned IDLE_LIMIT = 1000;
    localparam logic [7:0]  CH_A       = 8'h61;
    localparam logic [7:0]  CH_B       = 8'h62;

    typedef struct packed {
        t_action    act;
        logic [7:0] sym;
    } t_word;

    typedef struct packed {
        logic    matched;
        t_status status;
    } t_verdict;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dspm_in_if  in_if ();
    dspm_out_if out_if ();

    dot_star_pattern_matcher i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // Words waiting to be sent, and results the matcher still owes
    t_word    word_q[$];
    t_verdict verdict_q[$];

    // Predicted matcher state
    logic [7:0]       pat_byte[MAX_ATOMS];
    logic             pat_any[MAX_ATOMS];
    logic             pat_star[MAX_ATOMS];
    int               pat_cnt    = 0;
    logic [POS_W-1:0] live_set   = POS_W'(1);
    logic             text_seen  = 1'b0;
    logic             store_full = 1'b0;
    logic             order_bad  = 1'b0;

    int unsigned cyc_cnt     = 0;
    int unsigned idle_cycles = 0;
    int unsigned taken       = 0;
    int unsigned fail_cnt    = 0;
    int unsigned in_gap      = 0;
    int unsigned hold_out    = 0;
    logic        quiet;

    // No idling at all during part of every window
    assign quiet = (cyc_cnt % 1500) < 300;

    // Add every position reachable by skipping starred atoms
    function automatic logic [POS_W-1:0] close_live(input logic [POS_W-1:0] s);
        logic [POS_W-1:0] r;
        r = s;
        for (int i = 0; i < MAX_ATOMS; i++) begin
            if (i < pat_cnt && r[i] && pat_star[i]) begin
                r[i+1] = 1'b1;
            end
        end
        return r;
    endfunction

    // Advance the predicted state by one accepted word
    function automatic void match_step(input t_action act, input logic [7:0] sym);
        logic [POS_W-1:0] cur;
        logic [POS_W-1:0] nxt;
        t_verdict         v;
        cur = '0;
        nxt = '0;
        v   = '0;
        case (act)
            ACT_BEGIN: begin
                pat_cnt    = 0;
                live_set   = POS_W'(1);
                text_seen  = 1'b0;
                store_full = 1'b0;
                order_bad  = 1'b0;
            end
            ACT_PATTERN: begin
                if (text_seen) begin
                    order_bad = 1'b1;
                end else if (!store_full) begin
                    if (sym == SYM_STAR && pat_cnt > 0 && !pat_star[pat_cnt-1]) begin
                        pat_star[pat_cnt-1] = 1'b1;
                    end else if (pat_cnt >= MAX_ATOMS) begin
                        store_full = 1'b1;
                    end else begin
                        pat_byte[pat_cnt] = sym;
                        pat_any[pat_cnt]  = (sym == SYM_ANY);
                        pat_star[pat_cnt] = 1'b0;
                        pat_cnt++;
                    end
                end
            end
            ACT_TEXT: begin
                cur       = close_live(live_set);
                text_seen = 1'b1;
                for (int i = 0; i < MAX_ATOMS; i++) begin
                    if (i < pat_cnt && cur[i] && (pat_any[i] || pat_byte[i] == sym)) begin
                        if (pat_star[i]) begin
                            nxt[i] = 1'b1;
                        end else begin
                            nxt[i+1] = 1'b1;
                        end
                    end
                end
                live_set = close_live(nxt);
            end
            default: begin
                v.status  = store_full ? STAT_OVERFLOW : (order_bad ? STAT_ORDER : STAT_OK);
                cur       = close_live(live_set);
                v.matched = (v.status == STAT_OK) ? cur[pat_cnt] : 1'b0;
                verdict_q.push_back(v);
            end
        endcase
    endfunction

    function automatic void note_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 12) begin
            return 0;
        end else if (r < 18) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(6, 30);
        end
    endfunction

    // Pattern bytes from a small alphabet; dense keeps stars rare
    function automatic logic [7:0] pick_pat(input bit dense);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 9) begin
            return 8'($urandom_range(0, 255));
        end else if (r >= (dense ? 8 : 7)) begin
            return SYM_STAR;
        end else if (r >= 5) begin
            return SYM_ANY;
        end else begin
            return (r < 3) ? CH_A : CH_B;
        end
    endfunction

    function automatic logic [7:0] pick_txt();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return CH_A;
        end else if (r < 8) begin
            return CH_B;
        end else if (r == 8) begin
            return $urandom_range(0, 1) ? SYM_STAR : SYM_ANY;
        end else begin
            return 8'($urandom_range(0, 255));
        end
    endfunction

    function automatic void push_word(input t_action act, input logic [7:0] sym);
        t_word w;
        w.act = act;
        w.sym = sym;
        word_q.push_back(w);
    endfunction

    // Drive input words; advance only when the current word is taken
    always @(posedge i_clk) begin : drv
        t_word w;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_gap > 0) begin
                in_gap--;
                in_if.valid <= 1'b0;
            end else if (word_q.size() > 0) begin
                w = word_q.pop_front();
                in_if.action <= w.act;
                in_if.symbol <= w.sym;
                in_if.valid  <= 1'b1;
                in_gap = quiet ? 0 : pick_gap();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random
    always @(posedge i_clk) begin : rdy
        int unsigned gap;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_out > 0) begin
            out_if.ready <= 1'b0;
            hold_out--;
        end else begin
            gap = quiet ? 0 : pick_gap();
            out_if.ready <= (gap == 0);
            hold_out = (gap == 0) ? 0 : gap - 1;
        end
    end

    // Predict on accepted input words, check accepted result words
    always @(posedge i_clk) begin : mon
        t_verdict exp;
        logic     moved;
        moved = 1'b0;
        cyc_cnt++;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            match_step(t_action'(in_if.action), in_if.symbol);
            taken++;
            moved = 1'b1;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            moved = 1'b1;
            if (verdict_q.size() == 0) begin
                note_fail($sformatf("unexpected result matched=%0b status=%0d",
                                    out_if.matched, out_if.status));
            end else begin
                exp = verdict_q.pop_front();
                if (out_if.matched !== exp.matched || out_if.status !== exp.status) begin
                    note_fail($sformatf(
                        "expected matched=%0b status=%0d, got matched=%0b status=%0d",
                        exp.matched, exp.status, out_if.matched, out_if.status));
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    initial begin
        int unsigned kind;
        int unsigned plen;
        int unsigned tlen;
        int unsigned total;
        bit          timed_out;

        timed_out     = 1'b0;
        in_if.valid   = 1'b0;
        in_if.action  = ACT_BEGIN;
        in_if.symbol  = 8'h00;
        out_if.ready  = 1'b0;

        // Operate without a begin: a* against "aa"
        push_word(ACT_PATTERN, CH_A);
        push_word(ACT_PATTERN, SYM_STAR);
        push_word(ACT_TEXT, CH_A);
        push_word(ACT_TEXT, CH_A);
        push_word(ACT_END, 8'h00);
        // Empty pattern against empty text
        push_word(ACT_BEGIN, 8'hFF);
        push_word(ACT_END, 8'hFF);
        // Leading star is literal, next star folds, third star is literal again
        push_word(ACT_BEGIN, 8'h00);
        push_word(ACT_PATTERN, SYM_STAR);
        push_word(ACT_PATTERN, SYM_STAR);
        push_word(ACT_PATTERN, SYM_STAR);
        push_word(ACT_PATTERN, 8'h00);
        push_word(ACT_TEXT, SYM_STAR);
        push_word(ACT_TEXT, 8'h00);
        push_word(ACT_END, 8'h00);
        // Wildcard, then the same text extended after an end
        push_word(ACT_BEGIN, 8'h00);
        push_word(ACT_PATTERN, SYM_ANY);
        push_word(ACT_TEXT, 8'hFF);
        push_word(ACT_END, 8'h00);
        push_word(ACT_TEXT, 8'h00);
        push_word(ACT_END, 8'h00);
        // Pattern byte after text
        push_word(ACT_BEGIN, 8'h00);
        push_word(ACT_PATTERN, CH_A);
        push_word(ACT_TEXT, CH_A);
        push_word(ACT_PATTERN, CH_B);
        push_word(ACT_END, 8'h00);

        // Random sequences: mostly well-formed matches, some errors and noise
        total = word_q.size() + RAND_WORDS;
        while (word_q.size() < total) begin
            kind = $urandom_range(0, 99);
            if (kind >= 94) begin
                repeat ($urandom_range(1, 4)) begin
                    push_word(t_action'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
                end
            end else begin
                if (kind >= 70 || $urandom_range(0, 19) != 0) begin
                    push_word(ACT_BEGIN, 8'($urandom_range(0, 255)));
                end
                plen = (kind >= 70 && kind < 80) ? $urandom_range(15, 21) : $urandom_range(0, 7);
                repeat (plen) begin
                    push_word(ACT_PATTERN, pick_pat(kind >= 70 && kind < 80));
                end
                tlen = $urandom_range((kind >= 80 && kind < 88) ? 1 : 0, 9);
                repeat (tlen) begin
                    push_word(ACT_TEXT, pick_txt());
                end
                if (kind >= 80 && kind < 88) begin
                    push_word(ACT_PATTERN, pick_pat(1'b0));
                    if ($urandom_range(0, 1)) begin
                        push_word(ACT_TEXT, pick_txt());
                    end
                end
                push_word(ACT_END, 8'($urandom_range(0, 255)));
                if (kind >= 88) begin
                    repeat ($urandom_range(1, 3)) begin
                        push_word(ACT_TEXT, pick_txt());
                    end
                    push_word(ACT_END, 8'($urandom_range(0, 255)));
                end
            end
        end
        total = word_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hold until every word is taken and every result has come back
        while (!timed_out && (taken < total || verdict_q.size() > 0)) begin
            @(posedge i_clk);
            timed_out = (idle_cycles >= IDLE_LIMIT);
        end
        if (!timed_out) begin
            repeat (8) @(posedge i_clk);
        end

        if (timed_out) begin
            $display("simulation failed");
        end else if (fail_cnt == 0 && verdict_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/dspm_pkg.sv
design/dspm_in_if.sv
design/dspm_out_if.sv
design/dspm_ctrl.sv
design/dspm_datapath.sv
design/dot_star_pattern_matcher.sv
sim/dot_star_pattern_matcher_tb.sv
